[rtl/core/sobel_edge_magnitude_rgb_core_defines.svh]
// Assertion macros shared by the edge-magnitude core.
// No dependencies.
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_CORE_DEFINES_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_CORE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define SEM_ASSERT_IMP(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");
// Implication checked in the cycle after the antecedent.
`define SEM_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");
`endif

[rtl/core/sem_pkg.sv]
// Package for the edge-magnitude core: sizes, codes and the command/status types.
// No dependencies.
package sem_pkg;
   localparam int unsigned MaxWidthDefault  = 1024;
   localparam int unsigned MaxHeightDefault = 4096;
   localparam int unsigned CfgDataWidth     = 13;
   localparam int unsigned PixelWidth       = 24;

   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic ACTION_PIXEL = 1'b0;
   localparam logic ACTION_FLUSH = 1'b1;

   // Controller -> datapath
   typedef struct packed {
      logic       start;      // latch the item, launch line-store reads
      logic       compute;    // build window, start magnitude units
      logic       emit_first; // load output with left result
      logic       emit_second;// load output with end-of-row result
      logic       finish;     // update window, write stores
   } sem_cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic mag_done;
      logic has_first;
      logic has_second;
      logic out_busy;
   } sem_status_type;
endpackage

[rtl/core/sem_stream_if.sv]
// Valid/ready stream channel used on both sides of the core.
// No dependencies.
interface sem_stream_if #(parameter int unsigned DataWidth = 8);
   logic                 valid;
   logic                 ready;
   logic [DataWidth-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/sem_ram.sv]
// Single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sem_ram #(
   parameter int unsigned Width = 8,
   parameter int unsigned Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

[rtl/core/sem_isqrt.sv]
// Iterative rounded square root, one result bit per cycle, clamped to 255.
// No dependencies.
module sem_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [20:0] sum_sq,
   output logic        done,
   output logic [7:0]  result
);
   logic [20:0] s_ff, s_in;
   logic [7:0]  n_ff, n_in;
   logic [7:0]  bit_ff, bit_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [7:0]  trial;
   logic [15:0] prod;

   assign trial = n_ff | bit_ff;
   assign prod  = trial * (trial - 8'd1);

   always_comb begin
      s_in    = s_ff;
      n_in    = n_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         s_in    = sum_sq;
         bit_in  = 8'h80;
         if (sum_sq > 21'd64770) begin
            n_in    = 8'd255;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            n_in    = 8'd0;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if ({5'b00000, prod} < s_ff) begin
            n_in = trial;
         end
         bit_in = bit_ff >> 1;
         if (bit_ff == 8'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      s_ff   <= s_in;
      n_ff   <= n_in;
      bit_ff <= bit_in;
   end

   assign done   = done_ff;
   assign result = n_ff;
endmodule

[rtl/core/sem_datapath.sv]
// Datapath: line stores, 3x3 window, gradients, magnitude units, output register.
// Uses sem_pkg, sem_ram, sem_isqrt.
module sem_datapath #(
   parameter int unsigned MaxWidth  = sem_pkg::MaxWidthDefault,
   parameter int unsigned MaxHeight = sem_pkg::MaxHeightDefault
) (
   input  logic                        clock,
   input  logic                        reset,
   input  sem_pkg::sem_cmd_type        cmd,
   output sem_pkg::sem_status_type     status,
   input  logic [23:0]                 pixel,
   input  logic [$clog2(MaxWidth)-1:0] col,
   input  logic                        col_zero,
   input  logic                        end_row,
   input  logic                        draining,
   input  logic                        row_ge1,
   input  logic                        row_ge2,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [25:0]                 out_data
);
   import sem_pkg::*;
   localparam int unsigned AddrWidth = $clog2(MaxWidth);

   logic [23:0] above_rd, two_rd;
   logic [23:0] cur_ff;
   logic [AddrWidth-1:0] col_ff;
   logic [23:0] win_ff [6];
   logic [23:0] newcol [3];
   logic [23:0] lcol [3], mcol [3], rcol [3];
   logic        second_pass_ff, second_pass_in;
   logic        first_ff, second_ff, flush_ff, last_ff;
   logic [20:0] sq [3];
   logic [2:0]  done_v;
   logic [7:0]  mag [3];
   logic        out_valid_ff;
   logic [25:0] out_data_ff;
   logic [2:0]  done_seen_ff;

   sem_ram #(.Width(PixelWidth), .Depth(MaxWidth)) u_above (
      .clock(clock), .wr_en(cmd.finish && !flush_ff), .wr_addr(col_ff), .wr_data(cur_ff),
      .rd_addr(col), .rd_data(above_rd));
   sem_ram #(.Width(PixelWidth), .Depth(MaxWidth)) u_two (
      .clock(clock), .wr_en(cmd.finish && !flush_ff), .wr_addr(col_ff), .wr_data(above_rd),
      .rd_addr(col), .rd_data(two_rd));

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         cur_ff    <= draining ? 24'd0 : pixel;
         col_ff    <= col;
         flush_ff  <= draining;
         first_ff  <= row_ge1 && !col_zero;
         second_ff <= row_ge1 && end_row;
      end
   end

   assign newcol[0] = row_ge2 ? two_rd : 24'd0;
   assign newcol[1] = row_ge1 ? above_rd : 24'd0;
   assign newcol[2] = cur_ff;

   // select left/mid/right columns for the current pass
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (second_pass_ff) begin
            lcol[k] = col_zero ? 24'd0 : win_ff[3+k];
            mcol[k] = newcol[k];
            rcol[k] = 24'd0;
         end else begin
            lcol[k] = win_ff[k];
            mcol[k] = win_ff[3+k];
            rcol[k] = newcol[k];
         end
      end
   end

   // gradient per channel
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         logic signed [11:0] gx, gy;
         logic [4:0] sh;
         sh = 5'(16 - 8*c);
         gx = 12'(signed'({4'd0, 8'(rcol[0] >> sh)})) - 12'(signed'({4'd0, 8'(lcol[0] >> sh)}))
            + 12'(signed'({3'd0, 8'(rcol[1] >> sh), 1'b0}))
            - 12'(signed'({3'd0, 8'(lcol[1] >> sh), 1'b0}))
            + 12'(signed'({4'd0, 8'(rcol[2] >> sh)})) - 12'(signed'({4'd0, 8'(lcol[2] >> sh)}));
         gy = 12'(signed'({4'd0, 8'(lcol[2] >> sh)}))
            + 12'(signed'({3'd0, 8'(mcol[2] >> sh), 1'b0}))
            + 12'(signed'({4'd0, 8'(rcol[2] >> sh)}))
            - 12'(signed'({4'd0, 8'(lcol[0] >> sh)}))
            - 12'(signed'({3'd0, 8'(mcol[0] >> sh), 1'b0}))
            - 12'(signed'({4'd0, 8'(rcol[0] >> sh)}));
         sq[c] = 21'(24'(gx) * 24'(gx)) + 21'(24'(gy) * 24'(gy));
      end
   end

   for (genvar c = 0; c < 3; c++) begin : g_mag
      sem_isqrt u_isqrt (.clock(clock), .reset(reset), .start(cmd.compute),
                         .sum_sq(sq[c]), .done(done_v[c]), .result(mag[c]));
   end

   // after the first launch every later launch of this item is the end-of-row pass
   always_comb begin
      second_pass_in = second_pass_ff;
      if (cmd.start) second_pass_in = 1'b0;
      else if (cmd.compute) second_pass_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) win_ff[i] <= 24'd0;
         out_valid_ff   <= 1'b0;
         second_pass_ff <= 1'b0;
         done_seen_ff   <= 3'b000;
      end else begin
         second_pass_ff <= second_pass_in;
         if (cmd.compute) done_seen_ff <= 3'b000;
         else done_seen_ff <= done_seen_ff | done_v;
         if (out_valid_ff && out_ready) out_valid_ff <= 1'b0;
         if (cmd.emit_first || cmd.emit_second) out_valid_ff <= 1'b1;
         if (cmd.finish) begin
            for (int k = 0; k < 3; k++) begin
               win_ff[k]   <= col_zero ? 24'd0 : win_ff[3+k];
               win_ff[3+k] <= newcol[k];
            end
         end
      end
      if (cmd.emit_first) begin
         out_data_ff <= {mag[0], mag[1], mag[2], !second_ff, 1'b0};
      end else if (cmd.emit_second) begin
         out_data_ff <= {mag[0], mag[1], mag[2], 1'b1, flush_ff};
      end
   end

   // col_zero clears the window before the first pass reads it
   assign last_ff = 1'b0;
   assign status.mag_done   = ((done_seen_ff | done_v) == 3'b111) && !last_ff;
   assign status.has_first  = first_ff && !col_zero;
   assign status.has_second = second_ff;
   assign status.out_busy   = out_valid_ff && !out_ready;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
endmodule

[rtl/core/sem_ctrl.sv]
// Controller: sequences one item through read, compute and emit, tracks scan position.
// Uses sem_pkg.
module sem_ctrl #(
   parameter int unsigned MaxWidth  = sem_pkg::MaxWidthDefault,
   parameter int unsigned MaxHeight = sem_pkg::MaxHeightDefault
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic                        in_action,
   output logic                        in_ready,
   input  logic [10:0]                 cfg_width,
   input  logic [12:0]                 cfg_height,
   output sem_pkg::sem_cmd_type        cmd,
   input  sem_pkg::sem_status_type     status,
   output logic [$clog2(MaxWidth)-1:0] col,
   output logic                        col_zero,
   output logic                        end_row,
   output logic                        draining,
   output logic                        row_ge1,
   output logic                        row_ge2
);
   import sem_pkg::*;
   localparam int unsigned AddrWidth = $clog2(MaxWidth);
   localparam int unsigned RowWidth  = $clog2(MaxHeight + 1);
   localparam logic [2:0] ST_IDLE = 3'd0, ST_READ = 3'd1, ST_CALC = 3'd2,
                          ST_WAIT1 = 3'd3, ST_CALC2 = 3'd4, ST_WAIT2 = 3'd5,
                          ST_DONE = 3'd6;

   logic [2:0]           state_ff, state_in;
   logic [13:0]          col_ff, col_in;
   logic [RowWidth-1:0]  row_ff, row_in;
   logic                 drain_ff, drain_in;
   logic [13:0]          w;
   logic [16:0]          h;
   logic                 accept;

   always_comb begin
      if (cfg_width == 11'd0) w = 14'd1;
      else if ({3'd0, cfg_width} > 14'(MaxWidth)) w = 14'(MaxWidth);
      else w = {3'd0, cfg_width};
      if (cfg_height == 13'd0) h = 17'd1;
      else if ({4'd0, cfg_height} > 17'(MaxHeight)) h = 17'(MaxHeight);
      else h = {4'd0, cfg_height};
   end

   assign in_ready = (state_ff == ST_IDLE);
   assign accept   = in_valid && in_ready && (in_action == drain_ff);
   assign col      = col_ff[AddrWidth-1:0];
   assign col_zero = (col_ff == 14'd0);
   assign end_row  = col_ff >= w - 14'd1;
   assign draining = drain_ff;
   // the drain row sits at row index height
   assign row_ge1  = drain_ff || (row_ff >= RowWidth'(1));
   assign row_ge2  = drain_ff ? (h >= 17'd2) : (row_ff >= RowWidth'(2));

   always_comb begin
      state_in = state_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      drain_in = drain_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.start = 1'b1;
               state_in  = ST_READ;
            end
         end
         ST_READ: begin
            cmd.compute = 1'b1;
            state_in    = ST_CALC;
         end
         ST_CALC: begin
            if (!status.has_first) begin
               state_in = ST_WAIT1;
            end else if (status.mag_done && !status.out_busy) begin
               cmd.emit_first = 1'b1;
               state_in = ST_WAIT1;
            end
         end
         ST_WAIT1: begin
            if (status.has_second) begin
               cmd.compute = 1'b1;
               state_in = ST_CALC2;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_CALC2: begin
            state_in = ST_WAIT2;
         end
         ST_WAIT2: begin
            if (status.mag_done && !status.out_busy) begin
               cmd.emit_second = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
            if (end_row) begin
               col_in = 14'd0;
               if (drain_ff) begin
                  drain_in = 1'b0;
                  row_in   = '0;
               end else if (17'(row_ff) >= h - 17'd1) begin
                  drain_in = 1'b1;
                  row_in   = '0;
               end else begin
                  row_in = row_ff + RowWidth'(1);
               end
            end else begin
               col_in = col_ff + 14'd1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         col_ff   <= 14'd0;
         row_ff   <= '0;
         drain_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         drain_ff <= drain_in;
      end
   end
endmodule

[rtl/core/sobel_edge_magnitude_rgb_core.sv]
// Streaming 3x3 Sobel edge magnitude on RGB pixels.
// req channel: {action, in_red, in_green, in_blue}; action 1 is a flush step.
// rsp channel: {out_red, out_green, out_blue, last_in_run, end_of_frame}.
// csr port: index 0 image_width, index 1 image_height; write only while idle.
// An item whose action does not match the scan phase is taken and dropped.
// Each item walks a controller: line-store read, then per result an 8-step
// square-root iteration run by three per-channel units in parallel.
// An item yields no, one or two results; each result is emitted once the
// square roots are done, which is sooner when the sum saturates.
// After a frame, send image_width flush items to drain the bottom row.
// Reset (synchronous) clears scan position, window and output valid;
// line stores are not cleared. A stalled receiver holds the output register
// and the controller waits before loading the next result.
module sobel_edge_magnitude_rgb_core #(
   parameter int unsigned MaxWidth  = sem_pkg::MaxWidthDefault,
   parameter int unsigned MaxHeight = sem_pkg::MaxHeightDefault
) (
   input  logic        clock,
   input  logic        reset,
   sem_stream_if.sink   req,
   sem_stream_if.source rsp,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [12:0] csr_write_data
);
   import sem_pkg::*;
`include "sobel_edge_magnitude_rgb_core_defines.svh"

   logic [10:0] width_ff;
   logic [12:0] height_ff;
   sem_cmd_type    cmd;
   sem_status_type status;
   logic [$clog2(MaxWidth)-1:0] col;
   logic col_zero, end_row, draining, row_ge1, row_ge2;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 11'd1024;
         height_ff <= 13'd1;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_IMAGE_WIDTH) width_ff <= csr_write_data[10:0];
         else height_ff <= csr_write_data;
      end
   end

   sem_ctrl #(.MaxWidth(MaxWidth), .MaxHeight(MaxHeight)) u_ctrl (
      .clock(clock), .reset(reset), .in_valid(req.valid), .in_action(req.data[24]),
      .in_ready(req.ready), .cfg_width(width_ff), .cfg_height(height_ff),
      .cmd(cmd), .status(status), .col(col), .col_zero(col_zero), .end_row(end_row),
      .draining(draining), .row_ge1(row_ge1), .row_ge2(row_ge2));

   sem_datapath #(.MaxWidth(MaxWidth), .MaxHeight(MaxHeight)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .pixel(req.data[23:0]), .col(col), .col_zero(col_zero), .end_row(end_row),
      .draining(draining), .row_ge1(row_ge1), .row_ge2(row_ge2),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.data));

   `SEM_ASSERT_IMP(a_stall_hold, clock, reset, rsp.valid && !rsp.ready,
      !(cmd.emit_first || cmd.emit_second))
   `SEM_ASSERT_NEXT(a_emit_valid, clock, reset, cmd.emit_first || cmd.emit_second,
      rsp.valid)
   `SEM_ASSERT_IMP(a_one_cmd, clock, reset, 1'b1, $onehot0(cmd))
endmodule
